// File: hdl/npcb_pkg.sv
// Shared types and constants for the NVMe PRP command builder.
package npcb_pkg;

    localparam int IN_DATA_W  = 152;
    localparam int OUT_DATA_W = 296;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [1:0] KIND_SUBMIT   = 2'd0;
    localparam logic [1:0] KIND_LIST     = 2'd1;
    localparam logic [1:0] KIND_DOORBELL = 2'd2;
    localparam logic [1:0] KIND_REJECT   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_BS_LOG2   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NSID      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_QID       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LIST_BASE = 3'd4;

    localparam logic [7:0] OPC_READ  = 8'h02;
    localparam logic [7:0] OPC_WRITE = 8'h01;

    localparam logic [12:0] PAGE_BYTES    = 13'h1000;
    localparam logic [11:0] PAGE_MASK     = 12'hFFF;
    localparam logic [31:0] DOORBELL_BASE = 32'h0000_1000;
    localparam logic [16:0] MAX_COUNT     = 17'd65536;

    typedef struct packed {
        logic       capture;
        logic       calc_a;
        logic       calc_b;
        logic       load;
        logic [1:0] kind;
    } npcb_cmd_t;

    typedef struct packed {
        logic reject;
        logic has_list;
        logic list_end;
        logic out_free;
    } npcb_stat_t;

endpackage

// File: hdl/npcb_ctrl.sv
// Sequencing state machine of the NVMe PRP command builder.
module npcb_ctrl
    import npcb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  npcb_stat_t stat,
    output npcb_cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_CALC_A   = 3'd1;
    localparam logic [2:0] ST_CALC_B   = 3'd2;
    localparam logic [2:0] ST_LIST     = 3'd3;
    localparam logic [2:0] ST_SUBMIT   = 3'd4;
    localparam logic [2:0] ST_DOORBELL = 3'd5;
    localparam logic [2:0] ST_REJECT   = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        cmd.capture = 1'b0;
        cmd.calc_a  = 1'b0;
        cmd.calc_b  = 1'b0;
        cmd.load    = 1'b0;
        cmd.kind    = KIND_SUBMIT;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.capture = in_valid;
                if (in_valid)
                begin
                    state_next = ST_CALC_A;
                end
            end
            ST_CALC_A:
            begin
                cmd.calc_a = 1'b1;
                state_next = ST_CALC_B;
            end
            ST_CALC_B:
            begin
                cmd.calc_b = 1'b1;
                if (stat.reject)
                begin
                    state_next = ST_REJECT;
                end
                else
                begin
                    state_next = ST_SUBMIT;
                end
            end
            ST_SUBMIT:
            begin
                if (stat.has_list)
                begin
                    state_next = ST_LIST;
                end
                else
                begin
                    cmd.kind = KIND_SUBMIT;
                    cmd.load = stat.out_free;
                    if (stat.out_free)
                    begin
                        state_next = ST_DOORBELL;
                    end
                end
            end
            ST_LIST:
            begin
                cmd.kind = KIND_LIST;
                cmd.load = stat.out_free;
                if (stat.out_free && stat.list_end)
                begin
                    state_next = ST_SUBMIT;
                end
            end
            ST_DOORBELL:
            begin
                cmd.kind = KIND_DOORBELL;
                cmd.load = stat.out_free;
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_REJECT:
            begin
                cmd.kind = KIND_REJECT;
                cmd.load = stat.out_free;
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/npcb_dp.sv
// Datapath of the NVMe PRP command builder: registers, PRP math and result register.
module npcb_dp
    import npcb_pkg::*;
#(
    parameter int QUEUE_DEPTH  = 64,
    parameter int LIST_ENTRIES = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [IN_DATA_W-1:0]  in_data,
    input  logic                  in_func,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [OUT_DATA_W-1:0] out_data,
    output logic [1:0]            out_kind,
    output logic                  out_last,
    input  npcb_cmd_t             cmd,
    output npcb_stat_t            stat
);

    localparam int TAIL_W = $clog2(QUEUE_DEPTH);
    localparam int LIM_W  = $clog2(LIST_ENTRIES + 1);
    localparam int IDX_W  = $clog2(LIST_ENTRIES);

    logic [3:0]  bs_log2_reg;
    logic [31:0] nsid_reg;
    logic [7:0]  qid_reg;
    logic [3:0]  stride_reg;
    logic [63:0] list_base_reg;
    logic [TAIL_W-1:0] tail_reg;

    logic        func_reg;
    logic [63:0] lba_reg;
    logic [16:0] cnt_reg;
    logic [63:0] buf_reg;

    logic        reject_reg;
    logic        over_reg;
    logic [31:0] rest_reg;
    logic        has_list_reg;
    logic [LIM_W-1:0] lim_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [51:0] page_reg;
    logic [63:0] prp2_reg;

    logic        valid_reg;
    logic [1:0]  kind_reg;
    logic        last_reg;
    logic [5:0]  slot_reg;
    logic [7:0]  opc_reg;
    logic [31:0] ns_reg;
    logic [63:0] cmd_lba_reg;
    logic [15:0] cm1_reg;
    logic [63:0] prp_first_reg;
    logic [63:0] prp_second_reg;
    logic [31:0] dbo_reg;
    logic [5:0]  dbv_reg;

    logic [31:0] total;
    logic [12:0] first;
    logic [20:0] pages;
    logic [51:0] next_page;
    logic [4:0]  db_shift;
    logic [TAIL_W-1:0] tail_next;
    logic        out_free;

    assign cfg_ready = 1'b1;
    assign out_free  = !valid_reg || out_ready;

    assign total     = 32'(cnt_reg) << bs_log2_reg;
    assign first     = PAGE_BYTES - {1'b0, buf_reg[11:0]};
    assign pages     = 21'((33'(rest_reg) + 33'(PAGE_MASK)) >> 12);
    assign next_page = buf_reg[63:12] + 52'd1;
    assign db_shift  = {1'b0, stride_reg} + 5'd3;
    assign tail_next = (tail_reg == TAIL_W'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;

    assign stat.reject   = reject_reg;
    assign stat.has_list = has_list_reg;
    assign stat.list_end = ((LIM_W'(idx_reg) + 1'b1) == lim_reg);
    assign stat.out_free = out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bs_log2_reg   <= 4'd9;
            nsid_reg      <= 32'd1;
            qid_reg       <= 8'd1;
            stride_reg    <= 4'd0;
            list_base_reg <= 64'd0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_BS_LOG2:   bs_log2_reg   <= cfg_data[3:0];
                REG_NSID:      nsid_reg      <= cfg_data[31:0];
                REG_QID:       qid_reg       <= cfg_data[7:0];
                REG_STRIDE:    stride_reg    <= cfg_data[3:0];
                REG_LIST_BASE: list_base_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tail_reg     <= '0;
            valid_reg    <= 1'b0;
            has_list_reg <= 1'b0;
            reject_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.calc_a)
            begin
                reject_reg <= (cnt_reg == 17'd0) || (buf_reg == 64'd0) || (cnt_reg > MAX_COUNT);
            end
            if (cmd.calc_b)
            begin
                has_list_reg <= over_reg && (pages > 21'd1);
            end
            else if (cmd.load && cmd.kind == KIND_LIST && stat.list_end)
            begin
                has_list_reg <= 1'b0;
            end
            if (cmd.load && cmd.kind == KIND_SUBMIT)
            begin
                tail_reg <= tail_next;
            end
            if (cmd.load)
            begin
                valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg <= in_func;
            lba_reg  <= in_data[63:0];
            cnt_reg  <= in_data[80:64];
            buf_reg  <= in_data[144:81];
        end
        if (cmd.calc_a)
        begin
            over_reg <= total > 32'(first);
            rest_reg <= total - 32'(first);
        end
        if (cmd.calc_b)
        begin
            lim_reg  <= (pages < 21'(LIST_ENTRIES)) ? LIM_W'(pages) : LIM_W'(LIST_ENTRIES);
            idx_reg  <= '0;
            page_reg <= next_page;
            if (!over_reg)
            begin
                prp2_reg <= 64'd0;
            end
            else if (pages == 21'd1)
            begin
                prp2_reg <= {next_page, 12'd0};
            end
            else
            begin
                prp2_reg <= list_base_reg;
            end
        end
        if (cmd.load)
        begin
            kind_reg       <= cmd.kind;
            last_reg       <= 1'b0;
            slot_reg       <= 6'd0;
            opc_reg        <= 8'd0;
            ns_reg         <= 32'd0;
            cmd_lba_reg    <= 64'd0;
            cm1_reg        <= 16'd0;
            prp_first_reg  <= 64'd0;
            prp_second_reg <= 64'd0;
            dbo_reg        <= 32'd0;
            dbv_reg        <= 6'd0;
            case (cmd.kind)
                KIND_LIST:
                begin
                    slot_reg       <= 6'(idx_reg);
                    prp_second_reg <= {page_reg, 12'd0};
                    idx_reg        <= idx_reg + 1'b1;
                    page_reg       <= page_reg + 52'd1;
                end
                KIND_SUBMIT:
                begin
                    slot_reg       <= 6'(tail_reg);
                    opc_reg        <= func_reg ? OPC_WRITE : OPC_READ;
                    ns_reg         <= nsid_reg;
                    cmd_lba_reg    <= lba_reg;
                    cm1_reg        <= 16'(cnt_reg - 17'd1);
                    prp_first_reg  <= buf_reg;
                    prp_second_reg <= prp2_reg;
                end
                KIND_DOORBELL:
                begin
                    dbo_reg  <= DOORBELL_BASE + (32'(qid_reg) << db_shift);
                    dbv_reg  <= 6'(tail_reg);
                    last_reg <= 1'b1;
                end
                default:
                begin
                    last_reg <= 1'b1;
                end
            endcase
        end
    end

    assign out_valid = valid_reg;
    assign out_kind  = kind_reg;
    assign out_last  = last_reg;
    assign out_data  = {4'd0, dbv_reg, dbo_reg, prp_second_reg, prp_first_reg,
                        cm1_reg, cmd_lba_reg, ns_reg, opc_reg, slot_reg};

endmodule

// File: hdl/nvme_prp_command_builder_core.sv
// Top level of the NVMe PRP command builder.
//
//  Channel   Direction  Handshake                      Carries
//  s_axis    in         s_axis_tvalid/s_axis_tready    one read or write request
//  m_axis    out        m_axis_tvalid/m_axis_tready    list entries, submission, doorbell
//  cfg       in         cfg_valid/cfg_ready            register index and write data
//
// After its accept a request passes through the CALC_A and CALC_B states for the
// transfer and PRP math, then emits its results through the single result
// register: list entries, then the submission entry, then the doorbell. A list
// holds at most LIST_ENTRIES entries; a reject emits a single reject result
// instead. A stalled m_axis_tready holds the result register and the sequencer;
// s_axis_tready is high only between requests. Reset clears the tail pointer and
// loads the register reset values.
module nvme_prp_command_builder_core
    import npcb_pkg::*;
#(
    parameter int QUEUE_DEPTH  = 64,
    parameter int LIST_ENTRIES = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // start_lba[63:0], num_blocks[80:64], buffer_address[144:81], zero pad.
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // func[0].
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // slot, opcode, cmd_namespace, cmd_lba, count_minus_one, prp_first,
    // prp_second, doorbell_offset, doorbell_value, zero pad.
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // kind[1:0].
    output logic [1:0]            m_axis_tuser,
    output logic                  m_axis_tlast,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    npcb_cmd_t  cmd;
    npcb_stat_t stat;

    npcb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    npcb_dp #(
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .LIST_ENTRIES (LIST_ENTRIES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (s_axis_tdata),
        .in_func   (s_axis_tuser),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_kind  (m_axis_tuser),
        .out_last  (m_axis_tlast),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

// File: hdl/npcb_checker.sv
// Port-level assertions for the NVMe PRP command builder and their bind.
module npcb_checker
    import npcb_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic [1:0]            m_axis_tuser,
    input logic                  m_axis_tlast
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("Result changed while stalled.");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("Request accepted while the previous one is in progress.");

    a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            (m_axis_tlast == (m_axis_tuser == KIND_DOORBELL || m_axis_tuser == KIND_REJECT)))
        else $error("Last marker does not match the result kind.");

    a_reject_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_REJECT |-> m_axis_tdata == '0)
        else $error("Reject transaction carries data.");

endmodule

bind nvme_prp_command_builder_core npcb_checker u_npcb_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
